>>> hdl/csvtok_pkg.sv
// Shared types and constants for the CSV field tokenizer.
// Used by the parse core, the result queue, the top level and its checker.
package csvtok_pkg;

  // Widths of the payload fields
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned LEN_W    = 12;
  localparam int unsigned KIND_W   = 2;
  localparam int unsigned CFG_W    = 12;
  localparam int unsigned S_DATA_W = 8;
  localparam int unsigned M_DATA_W = 24;

  // Hard cap on kept characters; the limit in force is min(register, FIELD_LIMIT - 1)
  localparam int unsigned FIELD_LIMIT = 4096;

  // Default depth of the result queue, at least two
  localparam int unsigned RESQ_DEPTH = 4;

  // Register indexes on the configuration port
  localparam logic REG_MAX_FIELD_CHARS = 1'b0;
  localparam logic REG_SKIP_HEADER     = 1'b1;

  // Register reset values
  localparam logic [LEN_W-1:0] MAX_CHARS_RESET = 12'hFFF;
  localparam logic             SKIP_RESET      = 1'b1;

  // Character codes
  localparam logic [BYTE_W-1:0] CH_QUOTE = 8'h22;
  localparam logic [BYTE_W-1:0] CH_COMMA = 8'h2C;
  localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
  localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [BYTE_W-1:0] CH_NINE  = 8'h39;

  // Input word type carried on s_tuser
  localparam logic REQ_DATA = 1'b0;
  localparam logic REQ_END  = 1'b1;

  typedef enum logic [KIND_W-1:0] {
    KIND_CHAR   = 2'd0,
    KIND_COMMA  = 2'd1,
    KIND_RECORD = 2'd2,
    KIND_END    = 2'd3
  } out_kind_t;

  typedef enum logic [2:0] {
    MODE_HDR_CHECK  = 3'd0,
    MODE_HDR_SKIP   = 3'd1,
    MODE_START      = 3'd2,
    MODE_UNQUOTED   = 3'd3,
    MODE_QUOTED     = 3'd4,
    MODE_QUOTE_SEEN = 3'd5,
    MODE_AFTER_CR   = 3'd6
  } parse_mode_t;

  typedef struct packed {
    out_kind_t         kind;
    logic [BYTE_W-1:0] chr;
    logic [LEN_W-1:0]  len;
    logic              trunc;
    logic              last;
  } result_t;

  // Results produced by one accepted word, in order r0 then r1
  typedef struct packed {
    logic [1:0] n;
    result_t    r0;
    result_t    r1;
  } push_t;

endpackage

>>> hdl/csvtok_core.sv
// Parse state, configuration registers and the one-step parse logic.
// Depends on csvtok_pkg.
module csvtok_core import csvtok_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              take,
  input  logic              req_type,
  input  logic [BYTE_W-1:0] in_byte,
  input  logic              cfg_we,
  input  logic              cfg_addr,
  input  logic [CFG_W-1:0]  cfg_wdata,
  output push_t             push
);

  typedef enum logic [1:0] {
    ACT_NONE,
    ACT_START,
    ACT_KEEP,
    ACT_DELIM
  } act_t;

  localparam logic [16:0] FIELD_CAP = 17'(FIELD_LIMIT - 1);

  logic [LEN_W-1:0] max_field_chars;
  logic             skip_header_enable;
  parse_mode_t      mode, mode_next;
  logic [LEN_W-1:0] kept, kept_next;
  logic             dropped, dropped_next;
  logic             ended, ended_next;

  logic [LEN_W-1:0] limit;
  logic             is_quote, is_lf, is_cr, is_delim, is_digit;
  out_kind_t        delim_kind;
  act_t             act;

  assign limit = ({5'd0, max_field_chars} < FIELD_CAP) ? max_field_chars
                                                       : FIELD_CAP[LEN_W-1:0];

  assign is_quote   = (in_byte == CH_QUOTE);
  assign is_lf      = (in_byte == CH_LF);
  assign is_cr      = (in_byte == CH_CR);
  assign is_delim   = (in_byte == CH_COMMA) || is_lf || is_cr;
  assign is_digit   = in_byte inside {[CH_ZERO:CH_NINE]};
  assign delim_kind = (in_byte == CH_COMMA) ? KIND_COMMA : KIND_RECORD;

  always_comb begin
    mode_next    = mode;
    kept_next    = kept;
    dropped_next = dropped;
    ended_next   = ended;
    act          = ACT_NONE;
    push         = '0;
    if (take && !ended) begin
      if (req_type == REQ_END) begin
        ended_next = 1'b1;
        if (mode == MODE_UNQUOTED || mode == MODE_QUOTED || mode == MODE_QUOTE_SEEN) begin
          // close the open record, then flag the end
          push.n        = 2'd2;
          push.r0.kind  = KIND_RECORD;
          push.r0.len   = kept;
          push.r0.trunc = dropped;
          push.r0.last  = 1'b0;
          push.r1.kind  = KIND_END;
          push.r1.last  = 1'b1;
          kept_next     = '0;
          dropped_next  = 1'b0;
          mode_next     = MODE_START;
        end else begin
          push.n       = 2'd1;
          push.r0.kind = KIND_END;
          push.r0.last = 1'b1;
        end
      end else begin
        case (mode)
          MODE_HDR_CHECK: begin
            if (skip_header_enable && !is_digit) begin
              mode_next = is_lf ? MODE_START : MODE_HDR_SKIP;
            end else begin
              act = ACT_START;
            end
          end
          MODE_HDR_SKIP: begin
            if (is_lf) begin
              mode_next = MODE_START;
            end
          end
          MODE_UNQUOTED: begin
            act = is_delim ? ACT_DELIM : ACT_KEEP;
          end
          MODE_QUOTED: begin
            if (is_quote) begin
              mode_next = MODE_QUOTE_SEEN;
            end else begin
              act = ACT_KEEP;
            end
          end
          MODE_QUOTE_SEEN: begin
            if (is_quote) begin
              mode_next = MODE_QUOTED;
              act       = ACT_KEEP;
            end else if (is_delim) begin
              act = ACT_DELIM;
            end else begin
              // stray byte after a closing quote: drop it
              mode_next = MODE_QUOTED;
            end
          end
          MODE_AFTER_CR: begin
            if (is_lf) begin
              mode_next = MODE_START;
            end else begin
              act = ACT_START;
            end
          end
          default: begin
            act = ACT_START;
          end
        endcase

        if (act == ACT_START) begin
          if (is_quote) begin
            mode_next = MODE_QUOTED;
            act       = ACT_NONE;
          end else if (is_delim) begin
            act = ACT_DELIM;
          end else begin
            mode_next = MODE_UNQUOTED;
            act       = ACT_KEEP;
          end
        end

        case (act)
          ACT_KEEP: begin
            if (kept < limit) begin
              kept_next     = kept + 1'b1;
              push.n        = 2'd1;
              push.r0.kind  = KIND_CHAR;
              push.r0.chr   = in_byte;
              push.r0.len   = kept + 1'b1;
              push.r0.trunc = dropped;
              push.r0.last  = 1'b1;
            end else begin
              dropped_next = 1'b1;
            end
          end
          ACT_DELIM: begin
            push.n        = 2'd1;
            push.r0.kind  = delim_kind;
            push.r0.len   = kept;
            push.r0.trunc = dropped;
            push.r0.last  = 1'b1;
            kept_next     = '0;
            dropped_next  = 1'b0;
            mode_next     = is_cr ? MODE_AFTER_CR : MODE_START;
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_field_chars    <= MAX_CHARS_RESET;
      skip_header_enable <= SKIP_RESET;
      mode               <= MODE_HDR_CHECK;
      kept               <= '0;
      dropped            <= 1'b0;
      ended              <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          REG_MAX_FIELD_CHARS: max_field_chars    <= cfg_wdata[LEN_W-1:0];
          REG_SKIP_HEADER:     skip_header_enable <= cfg_wdata[0];
          default: begin
          end
        endcase
      end
      mode    <= mode_next;
      kept    <= kept_next;
      dropped <= dropped_next;
      ended   <= ended_next;
    end
  end

endmodule

>>> hdl/csvtok_resq.sv
// Small result queue: takes up to two words a cycle, gives one on out_ready.
// Depends on csvtok_pkg.
module csvtok_resq import csvtok_pkg::*; #(
  parameter int unsigned DEPTH = RESQ_DEPTH
) (
  input  logic    clk,
  input  logic    rst,
  input  push_t   push,
  output logic    room2,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_word
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  result_t       mem [DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr, wr_ptr1;
  logic [CW-1:0] count;
  logic          pop;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign wr_ptr1   = ptr_inc(wr_ptr);
  assign out_valid = (count != '0);
  assign out_word  = mem[rd_ptr];
  assign pop       = out_valid && out_ready;
  assign room2     = (count <= CW'(DEPTH - 2));

  always_ff @(posedge clk) begin
    if (push.n != 2'd0) begin
      mem[wr_ptr] <= push.r0;
    end
    if (push.n == 2'd2) begin
      mem[wr_ptr1] <= push.r1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      case (push.n)
        2'd1:    wr_ptr <= wr_ptr1;
        2'd2:    wr_ptr <= ptr_inc(wr_ptr1);
        default: wr_ptr <= wr_ptr;
      endcase
      if (pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      count <= count + CW'(push.n) - CW'(pop);
    end
  end

endmodule

>>> hdl/csv_field_tokenizer_unit.sv
// Top level of the CSV field tokenizer: stream ports, configuration port,
// parse core and result queue. Depends on csvtok_pkg, csvtok_core, csvtok_resq.
//
//  channel   dir  handshake          payload
//  s_*       in   s_tvalid/s_tready  tdata: in_byte; tuser: req_type
//  m_*       out  m_tvalid/m_tready  tdata: char, length, truncated; tuser: kind;
//                                    tlast: last_result
//  cfg_*     in   cfg_we             cfg_addr: register index; cfg_wdata: value
//
// One input word is parsed in the cycle it is accepted; its results (0, 1 or 2
// words) go into the result queue and show on m_* once older words have left.
// A word can be accepted every cycle; s_tready drops only when the queue has
// fewer than two free slots, since an end marker inside a field puts two words
// in at once. Results leave at one word per cycle while m_tready is high, so a
// steady run of single-result words flows without a gap.
// rst is synchronous: it restores the register defaults, returns the parser
// to the header check and empties the queue.
// A stall on m_* holds the queue head; s_* flows while two slots are free.
module csv_field_tokenizer_unit import csvtok_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = RESQ_DEPTH
) (
  input  logic                clk,
  input  logic                rst,
  // slave side
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [S_DATA_W-1:0] s_tdata,   // [7:0] in_byte
  input  logic                s_tuser,   // [0] req_type
  // master side
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [M_DATA_W-1:0] m_tdata,   // [7:0] out_char, [19:8] field_length,
                                         // [20] field_truncated, [23:21] zero
  output logic [KIND_W-1:0]   m_tuser,   // [1:0] out_kind
  output logic                m_tlast,   // last_result
  // configuration
  input  logic                cfg_we,
  input  logic                cfg_addr,
  input  logic [CFG_W-1:0]    cfg_wdata
);

  logic    take;
  logic    room2;
  push_t   push;
  result_t head;

  // accept a word whenever two queue slots are free
  assign s_tready = room2;
  assign take     = s_tvalid && s_tready;

  csvtok_core u_core (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .req_type  (s_tuser),
    .in_byte   (s_tdata[BYTE_W-1:0]),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .push      (push)
  );

  csvtok_resq #(
    .DEPTH (QUEUE_DEPTH)
  ) u_resq (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .room2     (room2),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_word  (head)
  );

  // pack the queue head onto the master side
  assign m_tdata = {3'b000, head.trunc, head.len, head.chr};
  assign m_tuser = head.kind;
  assign m_tlast = head.last;

endmodule

>>> hdl/csvtok_chk.sv
// Port-level checker for the CSV field tokenizer, bound to the top level.
// Depends on csvtok_pkg and csv_field_tokenizer_unit.
module csvtok_chk import csvtok_pkg::*; (
  input logic                clk,
  input logic                rst,
  input logic                m_tvalid,
  input logic                m_tready,
  input logic [M_DATA_W-1:0] m_tdata,
  input logic [KIND_W-1:0]   m_tuser,
  input logic                m_tlast
);

  // a stalled word holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
      && $stable(m_tlast))
    else $error("stalled result word changed");

  // the queue is empty right after reset
  a_empty_after_rst: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !m_tvalid)
    else $error("result word present right after reset");

  // a kept character always counts itself
  a_char_len: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == KIND_CHAR |-> m_tdata[19:8] != 12'd0)
    else $error("character word with zero length");

  // field ends and the end marker carry no character
  a_no_char: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser != KIND_CHAR |-> m_tdata[7:0] == 8'd0)
    else $error("non-character word carries a character");

  // the end marker is bare and closes its input word
  a_end_word: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == KIND_END |-> m_tlast && m_tdata[20:8] == 13'd0)
    else $error("malformed end-of-input word");

endmodule

bind csv_field_tokenizer_unit csvtok_chk u_chk (.*);

>>> verif/tb_csv_field_tokenizer_unit.sv
`timescale 1ns / 1ps
// Self-checking bench for csv_field_tokenizer_unit: drives bytes and end markers on the
// slave stream and checks every result word against the predictor or typed-in rows.
// Depends on csvtok_pkg and the RTL of the unit.
module tb_csv_field_tokenizer_unit import csvtok_pkg::*;;

  localparam int unsigned SETTLE_CYCLES = 8;     // settle time once every owed word has come
  localparam int unsigned STALL_LIMIT   = 2000;  // cycles with no handshake on either side
  localparam int unsigned RANDOM_ITEMS  = 600;
  localparam int unsigned PHASES        = 10;
  localparam logic [CFG_W-1:0] LONG_LIMIT = 12'd200;
  localparam int unsigned LONG_FIELD    = 204;

  // One line of stimulus: either a register write or an input word. Where typed_in is
  // set, the results are written into the row; otherwise the predictor supplies them.
  typedef struct packed {
    logic              is_cfg;
    logic              cfg_idx;
    logic [CFG_W-1:0]  cfg_val;
    logic              req;
    logic [BYTE_W-1:0] b;
    logic              typed_in;
    logic [1:0]        typed_n;
    result_t           r0;
    result_t           r1;
  } stim_row_t;

  logic                clk       = 1'b0;
  logic                rst       = 1'b1;
  logic                s_tvalid  = 1'b0;
  logic                s_tready;
  logic [S_DATA_W-1:0] s_tdata   = '0;
  logic                s_tuser   = REQ_DATA;
  logic                m_tvalid;
  logic                m_tready  = 1'b0;
  logic [M_DATA_W-1:0] m_tdata;
  logic [KIND_W-1:0]   m_tuser;
  logic                m_tlast;
  logic                cfg_we    = 1'b0;
  logic                cfg_addr  = REG_MAX_FIELD_CHARS;
  logic [CFG_W-1:0]    cfg_wdata = '0;

  // Tokenizer predictor: its own copy of the registers and the parse state
  logic [LEN_W-1:0] tok_char_limit = MAX_CHARS_RESET;
  logic             tok_skip_hdr   = SKIP_RESET;
  parse_mode_t      tok_mode       = MODE_HDR_CHECK;
  logic [LEN_W-1:0] tok_kept       = '0;
  logic             tok_dropped    = 1'b0;
  logic             tok_ended      = 1'b0;
  result_t          step_res [2];
  int               step_n;

  result_t pending_results [$];   // result words still owed by the unit, oldest first
  result_t want;
  int      err_count    = 0;
  int      sent_items   = 0;
  int      quiet_cycles = 0;
  bit      idle_on      = 1'b1;

  csv_field_tokenizer_unit dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------- predictor

  function automatic result_t res_word(out_kind_t kind, logic [BYTE_W-1:0] chr,
                                       logic [LEN_W-1:0] len, logic trunc,
                                       logic last = 1'b1);
    result_t r;
    r.kind  = kind;
    r.chr   = chr;
    r.len   = len;
    r.trunc = trunc;
    r.last  = last;
    return r;
  endfunction

  task automatic emit_result(out_kind_t kind, logic [BYTE_W-1:0] chr,
                             logic [LEN_W-1:0] len, logic trunc, logic last);
    step_res[step_n] = res_word(kind, chr, len, trunc, last);
    step_n++;
  endtask

  // Keep a character while under the limit in force; past it, drop and flag
  task automatic keep_char(logic [BYTE_W-1:0] b);
    logic [LEN_W-1:0] lim;
    lim = (tok_char_limit < LEN_W'(FIELD_LIMIT - 1)) ? tok_char_limit
                                                     : LEN_W'(FIELD_LIMIT - 1);
    if (tok_kept < lim) begin
      tok_kept = tok_kept + 1'b1;
      emit_result(KIND_CHAR, b, tok_kept, tok_dropped, 1'b1);
    end else begin
      tok_dropped = 1'b1;
    end
  endtask

  task automatic close_field(out_kind_t kind, parse_mode_t next, logic last);
    emit_result(kind, '0, tok_kept, tok_dropped, last);
    tok_kept    = '0;
    tok_dropped = 1'b0;
    tok_mode    = next;
  endtask

  // Comma, LF and CR end a field; hit stays low for any other byte
  task automatic take_delimiter(logic [BYTE_W-1:0] b, output bit hit);
    hit = 1'b1;
    if (b == CH_COMMA) close_field(KIND_COMMA, MODE_START, 1'b1);
    else if (b == CH_LF) close_field(KIND_RECORD, MODE_START, 1'b1);
    else if (b == CH_CR) close_field(KIND_RECORD, MODE_AFTER_CR, 1'b1);
    else hit = 1'b0;
  endtask

  task automatic open_field(logic [BYTE_W-1:0] b);
    bit hit;
    if (b == CH_QUOTE) begin
      tok_mode = MODE_QUOTED;
    end else begin
      take_delimiter(b, hit);
      if (!hit) begin
        tok_mode = MODE_UNQUOTED;
        keep_char(b);
      end
    end
  endtask

  // Advance the tokenizer by one accepted word; results land in step_res[0 .. step_n-1]
  task automatic tokenize_word(logic req, logic [BYTE_W-1:0] b);
    bit hit;
    step_n = 0;
    if (!tok_ended) begin
      if (req == REQ_END) begin
        // an open field is closed as a record end before the end marker itself
        if (tok_mode == MODE_UNQUOTED || tok_mode == MODE_QUOTED ||
            tok_mode == MODE_QUOTE_SEEN)
          close_field(KIND_RECORD, MODE_START, 1'b0);
        emit_result(KIND_END, '0, '0, 1'b0, 1'b1);
        tok_ended = 1'b1;
      end else begin
        case (tok_mode)
          MODE_HDR_CHECK: begin
            if (tok_skip_hdr && !(b >= CH_ZERO && b <= CH_NINE))
              tok_mode = (b == CH_LF) ? MODE_START : MODE_HDR_SKIP;
            else
              open_field(b);
          end
          MODE_HDR_SKIP: begin
            if (b == CH_LF) tok_mode = MODE_START;
          end
          MODE_UNQUOTED: begin
            take_delimiter(b, hit);
            if (!hit) keep_char(b);
          end
          MODE_QUOTED: begin
            if (b == CH_QUOTE) tok_mode = MODE_QUOTE_SEEN;
            else keep_char(b);
          end
          MODE_QUOTE_SEEN: begin
            if (b == CH_QUOTE) begin
              tok_mode = MODE_QUOTED;
              keep_char(CH_QUOTE);
            end else begin
              // a stray byte after the closing quote is dropped
              take_delimiter(b, hit);
              if (!hit) tok_mode = MODE_QUOTED;
            end
          end
          MODE_AFTER_CR: begin
            if (b == CH_LF) tok_mode = MODE_START;
            else open_field(b);
          end
          default: open_field(b);
        endcase
      end
    end
  endtask

  // ---------------------------------------------------------------- stimulus rows

  function automatic stim_row_t data_row(logic [BYTE_W-1:0] b);
    stim_row_t row;
    row     = '0;
    row.req = REQ_DATA;
    row.b   = b;
    return row;
  endfunction

  function automatic stim_row_t end_row(logic [BYTE_W-1:0] b);
    stim_row_t row;
    row     = data_row(b);
    row.req = REQ_END;
    return row;
  endfunction

  function automatic stim_row_t quiet_row(logic [BYTE_W-1:0] b);
    stim_row_t row;
    row          = data_row(b);
    row.typed_in = 1'b1;
    row.typed_n  = 2'd0;
    return row;
  endfunction

  function automatic stim_row_t char_row(logic [BYTE_W-1:0] b, result_t r);
    stim_row_t row;
    row          = data_row(b);
    row.typed_in = 1'b1;
    row.typed_n  = 2'd1;
    row.r0       = r;
    return row;
  endfunction

  function automatic stim_row_t cfg_row(logic idx, logic [CFG_W-1:0] val);
    stim_row_t row;
    row         = '0;
    row.is_cfg  = 1'b1;
    row.cfg_idx = idx;
    row.cfg_val = val;
    return row;
  endfunction

  // Field content: mostly printable, some raw bytes, some quotes and delimiters
  function automatic logic [BYTE_W-1:0] field_byte();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 55) return BYTE_W'($urandom_range(8'h7E, 8'h20));
    if (pick < 80) return BYTE_W'($urandom_range(8'hFF));
    case (pick % 4)
      0:       return CH_QUOTE;
      1:       return CH_COMMA;
      2:       return CH_CR;
      default: return CH_LF;
    endcase
  endfunction

  // Byte that can sit in an unquoted field without ending or quoting it
  function automatic logic [BYTE_W-1:0] plain_byte();
    logic [BYTE_W-1:0] b;
    do b = field_byte();
    while (b == CH_COMMA || b == CH_CR || b == CH_LF || b == CH_QUOTE);
    return b;
  endfunction

  function automatic int short_len();
    return ($urandom_range(99) < 85) ? $urandom_range(6) : $urandom_range(20, 7);
  endfunction

  function automatic logic [CFG_W-1:0] pick_limit();
    case ($urandom_range(7))
      0:       return '0;
      1:       return CFG_W'(1);
      2:       return CFG_W'($urandom_range(8, 2));
      3:       return MAX_CHARS_RESET;
      4:       return CFG_W'($urandom_range(4095));
      default: return CFG_W'($urandom_range(20));
    endcase
  endfunction

  // ---------------------------------------------------------------- drivers

  // Offer one word on the slave side; on acceptance, record what it must produce
  task automatic push_word(stim_row_t row);
    @(negedge clk);
    while (idle_on && $urandom_range(99) < 23) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= row.req;
    s_tdata  <= row.b;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sent_items++;
    tokenize_word(row.req, row.b);
    if (row.typed_in) begin
      if (row.typed_n >= 2'd1) pending_results.push_back(row.r0);
      if (row.typed_n >= 2'd2) pending_results.push_back(row.r1);
    end else begin
      for (int i = 0; i < step_n; i++) pending_results.push_back(step_res[i]);
    end
  endtask

  // Hold the sender until every owed word has come, then let the pipeline settle
  task automatic drain_results();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_register(logic idx, logic [CFG_W-1:0] val);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_MAX_FIELD_CHARS) tok_char_limit = val;
    else tok_skip_hdr = val[0];
  endtask

  // Record of quoted and bare fields, any line end; may hold a lone quote or stray byte
  task automatic send_record();
    int fields;
    int len;
    logic [BYTE_W-1:0] b;
    fields = $urandom_range(4, 1);
    for (int f = 0; f < fields; f++) begin
      len = short_len();
      if ($urandom_range(2) == 0) begin
        push_word(data_row(CH_QUOTE));
        for (int i = 0; i < len; i++) begin
          b = field_byte();
          push_word(data_row(b));
          // double an embedded quote, but now and then leave it single
          if (b == CH_QUOTE && $urandom_range(9) != 0) push_word(data_row(CH_QUOTE));
        end
        push_word(data_row(CH_QUOTE));
        if ($urandom_range(11) == 0) push_word(data_row(plain_byte()));
      end else begin
        repeat (len) push_word(data_row(plain_byte()));
      end
      if (f < fields - 1) push_word(data_row(CH_COMMA));
    end
    case ($urandom_range(2))
      0: push_word(data_row(CH_LF));
      1: push_word(data_row(CH_CR));
      default: begin
        push_word(data_row(CH_CR));
        push_word(data_row(CH_LF));
      end
    endcase
  endtask

  task automatic send_noise();
    repeat ($urandom_range(12, 1)) push_word(data_row(field_byte()));
  endtask

  // Receiver: stall about 23 percent of the time unless idling is switched off
  always @(negedge clk) begin
    m_tready <= !idle_on || ($urandom_range(99) >= 23);
  end

  // ---------------------------------------------------------------- checking

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] wanted);
    $display("[%0t] mismatch on %s: got 0x%0h, want 0x%0h", $time, what, got, wanted);
    err_count++;
  endtask

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result word", 32'(m_tdata), 32'd0);
      end else begin
        want = pending_results.pop_front();
        if (m_tuser !== want.kind)
          report_mismatch("out_kind", 32'(m_tuser), 32'(want.kind));
        if (m_tdata[7:0] !== want.chr)
          report_mismatch("out_char", 32'(m_tdata[7:0]), 32'(want.chr));
        if (m_tdata[19:8] !== want.len)
          report_mismatch("field_length", 32'(m_tdata[19:8]), 32'(want.len));
        if (m_tdata[20] !== want.trunc)
          report_mismatch("field_truncated", 32'(m_tdata[20]), 32'(want.trunc));
        if (m_tdata[M_DATA_W-1:21] !== '0)
          report_mismatch("tdata padding", 32'(m_tdata[M_DATA_W-1:21]), 32'd0);
        if (m_tlast !== want.last)
          report_mismatch("last_result", 32'(m_tlast), 32'(want.last));
      end
    end
  end

  // Watchdog: end the run when neither side moves a word for too long
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------- sequence

  initial begin
    stim_row_t directed_rows [$];
    int        goal;

    repeat (3) @(negedge clk);
    rst <= 1'b0;

    // Header skip: a non-digit first byte drops the line; CR and comma do not end it
    directed_rows.push_back(cfg_row(REG_SKIP_HEADER, CFG_W'(1)));
    directed_rows.push_back(quiet_row(8'h68));
    directed_rows.push_back(quiet_row(CH_CR));
    directed_rows.push_back(quiet_row(CH_COMMA));
    directed_rows.push_back(quiet_row(CH_LF));
    // bare field with byte extremes, closed by a comma
    directed_rows.push_back(char_row(CH_ZERO, res_word(KIND_CHAR, CH_ZERO, 12'd1, 1'b0)));
    directed_rows.push_back(char_row(8'hFF, res_word(KIND_CHAR, 8'hFF, 12'd2, 1'b0)));
    directed_rows.push_back(char_row(8'h00, res_word(KIND_CHAR, 8'h00, 12'd3, 1'b0)));
    directed_rows.push_back(char_row(CH_COMMA, res_word(KIND_COMMA, '0, 12'd3, 1'b0)));
    // quoted field: comma, LF and a doubled quote are plain characters
    directed_rows.push_back(quiet_row(CH_QUOTE));
    directed_rows.push_back(char_row(CH_COMMA, res_word(KIND_CHAR, CH_COMMA, 12'd1, 1'b0)));
    directed_rows.push_back(char_row(CH_LF, res_word(KIND_CHAR, CH_LF, 12'd2, 1'b0)));
    directed_rows.push_back(quiet_row(CH_QUOTE));
    directed_rows.push_back(char_row(CH_QUOTE, res_word(KIND_CHAR, CH_QUOTE, 12'd3, 1'b0)));
    directed_rows.push_back(quiet_row(CH_QUOTE));
    // stray byte after the closing quote keeps the field quoted; close it again,
    // then CRLF with the LF swallowed
    directed_rows.push_back(quiet_row(8'h78));
    directed_rows.push_back(quiet_row(CH_QUOTE));
    directed_rows.push_back(char_row(CH_CR, res_word(KIND_RECORD, '0, 12'd3, 1'b0)));
    directed_rows.push_back(quiet_row(CH_LF));
    directed_rows.push_back(char_row(CH_COMMA, res_word(KIND_COMMA, '0, 12'd0, 1'b0)));
    directed_rows.push_back(char_row(CH_CR, res_word(KIND_RECORD, '0, 12'd0, 1'b0)));
    directed_rows.push_back(char_row(8'h61, res_word(KIND_CHAR, 8'h61, 12'd1, 1'b0)));
    // limit of one: the second character is dropped and flagged
    directed_rows.push_back(cfg_row(REG_MAX_FIELD_CHARS, CFG_W'(1)));
    directed_rows.push_back(quiet_row(8'h62));
    directed_rows.push_back(char_row(CH_LF, res_word(KIND_RECORD, '0, 12'd1, 1'b1)));
    // limit of zero: nothing is kept at all
    directed_rows.push_back(cfg_row(REG_MAX_FIELD_CHARS, '0));
    directed_rows.push_back(quiet_row(8'h63));
    directed_rows.push_back(char_row(CH_COMMA, res_word(KIND_COMMA, '0, 12'd0, 1'b1)));
    directed_rows.push_back(data_row(CH_QUOTE));
    directed_rows.push_back(data_row(8'h7F));
    directed_rows.push_back(data_row(CH_CR));
    directed_rows.push_back(cfg_row(REG_MAX_FIELD_CHARS, MAX_CHARS_RESET));

    foreach (directed_rows[i]) begin
      if (directed_rows[i].is_cfg)
        write_register(directed_rows[i].cfg_idx, directed_rows[i].cfg_val);
      else
        push_word(directed_rows[i]);
    end

    // Random records and noise in phases, a fresh limit per phase; one phase runs with no idling
    for (int phase = 0; phase < PHASES; phase++) begin
      write_register(REG_MAX_FIELD_CHARS, pick_limit());
      if (phase == 0 || $urandom_range(3) == 0)
        write_register(REG_SKIP_HEADER, CFG_W'($urandom_range(1)));
      idle_on <= (phase != 3);
      goal = sent_items + RANDOM_ITEMS / PHASES;
      while (sent_items < goal) begin
        if ($urandom_range(9) == 0) send_noise();
        else send_record();
      end
    end

    // One field past a configured limit: length tops out and the field is flagged
    write_register(REG_MAX_FIELD_CHARS, LONG_LIMIT);
    idle_on <= 1'b1;
    repeat (LONG_FIELD) push_word(data_row(plain_byte()));
    push_word(data_row(CH_LF));

    // End inside a quoted field, then words after the end that must stay silent
    push_word(data_row(CH_QUOTE));
    push_word(data_row(8'h7A));
    push_word(end_row(BYTE_W'($urandom_range(255))));
    repeat (4) push_word(data_row(field_byte()));
    push_word(end_row(BYTE_W'($urandom_range(255))));

    drain_results();
    if (err_count == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
